// File: rtl/mwcce_pkg.sv
// Shared types, method codes and arithmetic helpers for the CRC and checksum engine.
package mwcce_pkg;

    typedef logic [2:0] method_t;
    typedef logic [5:0] width_t;

    localparam method_t METH_NONE  = 3'd0;
    localparam method_t METH_CRC8  = 3'd1;
    localparam method_t METH_CRC16 = 3'd2;
    localparam method_t METH_CRC32 = 3'd3;
    localparam method_t METH_SUM8  = 3'd4;
    localparam method_t METH_SUM16 = 3'd5;
    localparam method_t METH_SUM32 = 3'd6;

    localparam logic CFG_IDX_PREAMBLE = 1'b0;
    localparam logic CFG_IDX_CARGO    = 1'b1;

    localparam logic [31:0] POLY8  = 32'h0000_0007;
    localparam logic [31:0] POLY16 = 32'h0000_8005;
    localparam logic [31:0] POLY32 = 32'h04C1_1DB7;
    localparam logic [31:0] INIT16 = 32'h0000_FFFF;
    localparam logic [31:0] INIT32 = 32'hFFFF_FFFF;

    // Running state of one open section
    typedef struct packed {
        logic [31:0] crc;
        logic [31:0] acc;
        logic [31:0] chunk;
        logic [4:0]  fill;
    } eng_state_t;

    // Closing request handed to the finish stage
    typedef struct packed {
        method_t     meth;
        logic        action;
        logic [31:0] crc;
        logic [31:0] acc;
        logic [31:0] chunk;
        logic        part;
        logic [31:0] rx;
    } fin_req_t;

    function automatic width_t meth_width(method_t m);
        width_t w;
        unique case (m)
            METH_CRC8,  METH_SUM8:  w = 6'd8;
            METH_CRC16, METH_SUM16: w = 6'd16;
            METH_CRC32, METH_SUM32: w = 6'd32;
            default:                w = 6'd0;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] width_mask(width_t w);
        return (w >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
    endfunction

    function automatic logic is_crc(method_t m);
        return (m == METH_CRC8) || (m == METH_CRC16) || (m == METH_CRC32);
    endfunction

    function automatic logic is_sum(method_t m);
        return (m == METH_SUM8) || (m == METH_SUM16) || (m == METH_SUM32);
    endfunction

    // Ones' complement add with end-around carry; operands below 2^w
    function automatic logic [31:0] ones_add(logic [31:0] a, logic [31:0] b, width_t w);
        logic [32:0] s;
        logic        c;
        s = {1'b0, a} + {1'b0, b};
        c = s[w];
        return (s[31:0] + {31'd0, c}) & width_mask(w);
    endfunction

endpackage

// File: rtl/mwcce_step.sv
// Per-request state update: up to eight CRC bit steps and sum chunk packing.
module mwcce_step (
    input  mwcce_pkg::eng_state_t st_cur,
    input  mwcce_pkg::method_t    meth,
    input  logic [7:0]            data_bits,
    input  logic [3:0]            bit_count,
    output mwcce_pkg::eng_state_t st_next
);
    import mwcce_pkg::*;

    width_t      w;
    logic [31:0] mask;
    logic [31:0] poly;
    logic [3:0]  cnt;
    logic [7:0]  data_m;
    logic [4:0]  tidx;
    logic [31:0] crc;
    logic        fb;
    logic [5:0]  shamt;
    logic [39:0] placed;
    logic [5:0]  fill_sum;
    logic        full;
    logic [31:0] chunk;

    always_comb begin
        w      = meth_width(meth);
        mask   = width_mask(w);
        cnt    = (bit_count > 4'd8) ? 4'd8 : bit_count;
        data_m = data_bits & ~(8'hFF >> cnt);
        tidx   = 5'(w - 6'd1);
        unique case (meth)
            METH_CRC8:  poly = POLY8;
            METH_CRC16: poly = POLY16;
            default:    poly = POLY32;
        endcase

        // CRC, MSB first, one bit per step
        crc = st_cur.crc;
        fb  = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < cnt) begin
                fb  = crc[tidx] ^ data_m[7 - i];
                crc = (crc << 1) & mask;
                if (fb) begin
                    crc = crc ^ poly;
                end
            end
        end

        // Sum: bit k of the window is chunk position k-8, low byte spills
        shamt    = w - {1'b0, st_cur.fill};
        placed   = {32'd0, data_m} << shamt;
        fill_sum = {1'b0, st_cur.fill} + {2'b00, cnt};
        full     = (fill_sum >= w);
        chunk    = st_cur.chunk | placed[39:8];

        st_next = st_cur;
        if (is_crc(meth)) begin
            st_next.crc = crc;
        end
        if (is_sum(meth)) begin
            if (full) begin
                st_next.acc   = ones_add(st_cur.acc, chunk, w);
                st_next.chunk = {24'd0, placed[7:0]} << (w - 6'd8);
                st_next.fill  = 5'(fill_sum - w);
            end else begin
                st_next.chunk = chunk;
                st_next.fill  = fill_sum[4:0];
            end
        end
    end

endmodule

// File: rtl/mwcce_finish.sv
// Closing stage: final fold, width mask, check compare and the result register.
module mwcce_finish (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fin_valid,
    output logic                fin_ready,
    input  mwcce_pkg::fin_req_t fin_req,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [31:0]         m_code,
    output logic [5:0]          m_code_bits,
    output logic                m_mismatch
);
    import mwcce_pkg::*;

    logic        m_valid_reg;
    logic [31:0] code_reg;
    logic [5:0]  bits_reg;
    logic        mis_reg;

    width_t      w;
    logic [31:0] mask;
    logic [31:0] code_next;
    logic        mis_next;

    always_comb begin
        w    = meth_width(fin_req.meth);
        mask = width_mask(w);
        if (is_crc(fin_req.meth)) begin
            code_next = ((fin_req.meth == METH_CRC32) ? ~fin_req.crc : fin_req.crc) & mask;
        end else if (is_sum(fin_req.meth)) begin
            code_next = (fin_req.part ? ones_add(fin_req.acc, fin_req.chunk, w)
                                      : fin_req.acc) & mask;
        end else begin
            code_next = 32'd0;
        end
        mis_next = fin_req.action && (w != 6'd0) && ((fin_req.rx & mask) != code_next);
    end

    assign fin_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fin_ready) begin
            m_valid_reg <= fin_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_valid && fin_ready) begin
            code_reg <= code_next;
            bits_reg <= w;
            mis_reg  <= mis_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_code      = code_reg;
    assign m_code_bits = bits_reg;
    assign m_mismatch  = mis_reg;

    a_bits_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (bits_reg == 6'd0 || bits_reg == 6'd8 ||
                         bits_reg == 6'd16 || bits_reg == 6'd32))
        else $error("code width not a method width");

    a_mis_needs_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && mis_reg |-> bits_reg != 6'd0)
        else $error("mismatch flagged with no code");

    a_code_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((code_reg & ~width_mask(bits_reg)) == 32'd0))
        else $error("code wider than its width");

endmodule

// File: rtl/multi_width_crc_checksum_engine_core.sv
// Top level of the CRC-8/16/32 and ones' complement checksum engine.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  s_      | in        | s_valid / s_ready   | action, section, data_bits, bit_count,
//          |           |                     | last, received_code
//  m_      | out       | m_valid / m_ready   | code, code_bits, mismatch (one per last)
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_index (0 preamble, 1 cargo), cfg_data
//
//  One request per cycle sustained while a last request finds room in the closing register.
//  A request moves input register -> section state and closing register -> result
//  register. The critical path is the eight unrolled CRC bit steps.
//  Reset (aresetn low at a clock edge) closes any open section and zeroes both method
//  registers; no clearing pass. A stalled m_ready backs up through the closing
//  register; non-last requests keep flowing while one result waits.
module multi_width_crc_checksum_engine_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic        s_section,
    input  logic [7:0]  s_data_bits,
    input  logic [3:0]  s_bit_count,
    input  logic        s_last,
    input  logic [31:0] s_received_code,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_code,
    output logic [5:0]  m_code_bits,
    output logic        m_mismatch,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [2:0]  cfg_data
);
    import mwcce_pkg::*;

    // method registers
    method_t     pre_meth_reg;
    method_t     cargo_meth_reg;

    // input register; method is picked at acceptance
    logic        in_vld_reg;
    logic        in_action_reg;
    logic [7:0]  in_data_reg;
    logic [3:0]  in_cnt_reg;
    logic        in_last_reg;
    logic [31:0] in_rx_reg;
    method_t     in_meth_reg;

    // open-section state
    logic        in_sec_reg;
    method_t     act_meth_reg;
    eng_state_t  st_reg;

    // closing register
    logic        fin_vld_reg;
    fin_req_t    fin_reg;

    method_t     meth_eff;
    eng_state_t  st_start;
    eng_state_t  st_eff;
    eng_state_t  st_next;
    fin_req_t    fin_next;
    logic        fin_ready;
    logic        fin_free;
    logic        in_go;

    assign cfg_ready = 1'b1;

    // A request with no open section starts one with fresh state
    always_comb begin
        meth_eff = in_sec_reg ? act_meth_reg : in_meth_reg;
        st_start = '0;
        if (in_meth_reg == METH_CRC16) begin
            st_start.crc = INIT16;
        end else if (in_meth_reg == METH_CRC32) begin
            st_start.crc = INIT32;
        end
        st_eff = in_sec_reg ? st_reg : st_start;
    end

    mwcce_step u_step (
        .st_cur    (st_eff),
        .meth      (meth_eff),
        .data_bits (in_data_reg),
        .bit_count (in_cnt_reg),
        .st_next   (st_next)
    );

    always_comb begin
        fin_next.meth   = meth_eff;
        fin_next.action = in_action_reg;
        fin_next.crc    = st_next.crc;
        fin_next.acc    = st_next.acc;
        fin_next.chunk  = st_next.chunk;
        fin_next.part   = (st_next.fill != 5'd0);
        fin_next.rx     = in_rx_reg;
    end

    // Flow: only a last request needs room in the closing register
    assign fin_free = !fin_vld_reg || fin_ready;
    assign in_go    = in_vld_reg && (!in_last_reg || fin_free);
    assign s_ready  = !in_vld_reg || in_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_meth_reg   <= METH_NONE;
            cargo_meth_reg <= METH_NONE;
            in_vld_reg     <= 1'b0;
            in_sec_reg     <= 1'b0;
            act_meth_reg   <= METH_NONE;
            fin_vld_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_IDX_PREAMBLE: pre_meth_reg   <= cfg_data;
                    CFG_IDX_CARGO:    cargo_meth_reg <= cfg_data;
                endcase
            end
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (in_go) begin
                in_sec_reg   <= !in_last_reg;
                act_meth_reg <= meth_eff;
            end
            if (fin_free) begin
                fin_vld_reg <= in_go && in_last_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg <= s_action;
            in_data_reg   <= s_data_bits;
            in_cnt_reg    <= s_bit_count;
            in_last_reg   <= s_last;
            in_rx_reg     <= s_received_code;
            in_meth_reg   <= s_section ? cargo_meth_reg : pre_meth_reg;
        end
        if (in_go) begin
            st_reg <= st_next;
        end
        if (in_go && in_last_reg && fin_free) begin
            fin_reg <= fin_next;
        end
    end

    mwcce_finish u_finish (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fin_valid   (fin_vld_reg),
        .fin_ready   (fin_ready),
        .fin_req     (fin_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_code      (m_code),
        .m_code_bits (m_code_bits),
        .m_mismatch  (m_mismatch)
    );

    // partial chunk never reaches the chunk width
    a_fill_below_width: assert property (@(posedge aclk) disable iff (!aresetn)
        in_sec_reg && is_sum(act_meth_reg) |->
            ({1'b0, st_reg.fill} < meth_width(act_meth_reg)))
        else $error("chunk fill reached width");

    // a waiting closing request is neither lost nor altered
    a_fin_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_vld_reg && !fin_ready |=> fin_vld_reg && $stable(fin_reg))
        else $error("closing request changed while stalled");

    // a last request never leaves the section open
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        in_go && in_last_reg |=> !in_sec_reg)
        else $error("section left open after last");

endmodule
